[sv/tfd_pkg.sv]
// Shared types, constants and command codes of the tree farthest distance block.
package tfd_pkg;

  localparam int MAX_NODES   = 32768;
  localparam int WEIGHT_BITS = 16;

  localparam int LINK_DEPTH = 2 * MAX_NODES;
  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int NCNT_BITS  = $clog2(MAX_NODES + 1);
  localparam int LINK_BITS  = $clog2(LINK_DEPTH);
  localparam int HEAD_BITS  = LINK_BITS + 1;
  localparam int LEN_BITS   = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int DIST_BITS  = 31;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [1:0] REQ_EDGE    = 2'd0;
  localparam logic [1:0] REQ_COMPUTE = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] end_a;
    logic [14:0] end_b;
    logic [15:0] edge_weight;
    logic [14:0] query_node;
  } in_item_t;

  typedef struct packed {
    logic [14:0] node_index;
    logic [30:0] farthest_distance;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SWEEP,
    OP_EDGE_RDA,
    OP_EDGE_WRA,
    OP_EDGE_RDB,
    OP_EDGE_WRB,
    OP_WALK_INIT,
    OP_POP,
    OP_NODE_RD,
    OP_NODE,
    OP_LINK_RD,
    OP_SEEN_RD,
    OP_VISIT,
    OP_QUERY_RD,
    OP_QUERY_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clr_head;
    logic   clr_seen;
    logic   clr_d1;
    logic   clr_d2;
    logic   dest_d2;
    logic   src_best;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic queue_empty;
    logic link_null;
    logic edge_ok;
    logic start_ok;
    logic query_ok;
    logic out_full;
  } dp_status_t;

endpackage

[sv/tfd_ctrl.sv]
// Controller state machine of the tree farthest distance block.
module tfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  output logic                in_ready,
  output tfd_pkg::dp_cmd_t    cmd,
  input  tfd_pkg::dp_status_t status
);
  import tfd_pkg::*;

  typedef enum logic [15:0] {
    S_CLEAR     = 16'b0000_0000_0000_0001,
    S_IDLE      = 16'b0000_0000_0000_0010,
    S_EDGE_RDA  = 16'b0000_0000_0000_0100,
    S_EDGE_WRA  = 16'b0000_0000_0000_1000,
    S_EDGE_RDB  = 16'b0000_0000_0001_0000,
    S_EDGE_WRB  = 16'b0000_0000_0010_0000,
    S_SWEEP     = 16'b0000_0000_0100_0000,
    S_INIT      = 16'b0000_0000_1000_0000,
    S_POP       = 16'b0000_0001_0000_0000,
    S_NODE_RD   = 16'b0000_0010_0000_0000,
    S_NODE      = 16'b0000_0100_0000_0000,
    S_LINK_RD   = 16'b0000_1000_0000_0000,
    S_SEEN_RD   = 16'b0001_0000_0000_0000,
    S_VISIT     = 16'b0010_0000_0000_0000,
    S_QUERY_RD  = 16'b0100_0000_0000_0000,
    S_QUERY_OUT = 16'b1000_0000_0000_0000
  } state_t;

  localparam logic [1:0] WALK_FIRST  = 2'd0;
  localparam logic [1:0] WALK_SECOND = 2'd1;
  localparam logic [1:0] WALK_THIRD  = 2'd2;

  state_t     state, state_next;
  logic [1:0] walk, walk_next;
  logic       computed, computed_next;
  logic       pend_edge, pend_edge_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    walk_next      = walk;
    computed_next  = computed;
    pend_edge_next = pend_edge;
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.dest_d2    = (walk != WALK_SECOND);
    cmd.src_best   = (walk != WALK_FIRST);
    case (state)
      S_CLEAR: begin
        cmd.op       = OP_SWEEP;
        cmd.clr_head = 1'b1;
        if (status.sweep_last) begin
          state_next     = pend_edge ? S_EDGE_RDA : S_IDLE;
          pend_edge_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          case (req_type)
            REQ_EDGE: begin
              if (computed) begin
                computed_next  = 1'b0;
                pend_edge_next = 1'b1;
                state_next     = S_CLEAR;
              end else begin
                state_next = S_EDGE_RDA;
              end
            end
            REQ_COMPUTE: begin
              walk_next  = WALK_FIRST;
              state_next = S_SWEEP;
            end
            REQ_QUERY: state_next = computed ? S_QUERY_RD : S_IDLE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE_RDA: begin
        if (status.edge_ok) begin
          cmd.op     = OP_EDGE_RDA;
          state_next = S_EDGE_WRA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EDGE_WRA: begin
        cmd.op     = OP_EDGE_WRA;
        state_next = S_EDGE_RDB;
      end
      S_EDGE_RDB: begin
        cmd.op     = OP_EDGE_RDB;
        state_next = S_EDGE_WRB;
      end
      S_EDGE_WRB: begin
        cmd.op     = OP_EDGE_WRB;
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        cmd.op       = OP_SWEEP;
        cmd.clr_seen = 1'b1;
        cmd.clr_d1   = (walk == WALK_FIRST);
        cmd.clr_d2   = (walk != WALK_THIRD);
        if (status.sweep_last) begin
          if (walk == WALK_FIRST && !status.start_ok) begin
            computed_next = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.op     = OP_WALK_INIT;
        state_next = S_POP;
      end
      S_POP: begin
        if (status.queue_empty) begin
          if (walk == WALK_THIRD) begin
            computed_next = 1'b1;
            state_next    = S_IDLE;
          end else begin
            walk_next  = walk + 2'd1;
            state_next = S_SWEEP;
          end
        end else begin
          cmd.op     = OP_POP;
          state_next = S_NODE_RD;
        end
      end
      S_NODE_RD: begin
        cmd.op     = OP_NODE_RD;
        state_next = S_NODE;
      end
      S_NODE: begin
        cmd.op     = OP_NODE;
        state_next = S_LINK_RD;
      end
      S_LINK_RD: begin
        if (status.link_null) begin
          state_next = S_POP;
        end else begin
          cmd.op     = OP_LINK_RD;
          state_next = S_SEEN_RD;
        end
      end
      S_SEEN_RD: begin
        cmd.op     = OP_SEEN_RD;
        state_next = S_VISIT;
      end
      S_VISIT: begin
        cmd.op     = OP_VISIT;
        state_next = S_LINK_RD;
      end
      S_QUERY_RD: begin
        if (status.query_ok) begin
          cmd.op     = OP_QUERY_RD;
          state_next = S_QUERY_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_QUERY_OUT: begin
        if (!status.out_full) begin
          cmd.op     = OP_QUERY_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      walk      <= WALK_FIRST;
      computed  <= 1'b0;
      pend_edge <= 1'b0;
    end else begin
      state     <= state_next;
      walk      <= walk_next;
      computed  <= computed_next;
      pend_edge <= pend_edge_next;
    end
  end

endmodule

[sv/tfd_dp.sv]
// Datapath of the tree farthest distance block: link stores, walk queue, distances.
module tfd_dp (
  input  logic                clk,
  input  logic                rst,
  input  tfd_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output tfd_pkg::out_item_t  out_data,
  input  tfd_pkg::dp_cmd_t    cmd,
  output tfd_pkg::dp_status_t status
);
  import tfd_pkg::*;

  // Storage
  logic [HEAD_BITS-1:0] head_mem  [MAX_NODES];
  logic [14:0]          tgt_mem   [LINK_DEPTH];
  logic [HEAD_BITS-1:0] onw_mem   [LINK_DEPTH];
  logic [LEN_BITS-1:0]  len_mem   [LINK_DEPTH];
  logic [DIST_BITS-1:0] d1_mem    [MAX_NODES];
  logic [DIST_BITS-1:0] d2_mem    [MAX_NODES];
  logic                 seen_mem  [MAX_NODES];
  logic [14:0]          queue_mem [MAX_NODES];

  // Registers
  logic [15:0]          node_count;
  logic [14:0]          req_a, req_b, req_q;
  logic [LEN_BITS-1:0]  req_w;
  logic [HEAD_BITS-1:0] links;
  logic [14:0]          start;
  logic [NODE_BITS-1:0] sweep_idx;
  logic [NCNT_BITS-1:0] qhead, qtail;
  logic [14:0]          best, cur_u, cur_x;
  logic [DIST_BITS-1:0] bestd, cur_du;
  logic [HEAD_BITS-1:0] cur_l, cur_onw;
  logic [LEN_BITS-1:0]  cur_len;

  // Read data
  logic [HEAD_BITS-1:0] head_rd, onw_rd;
  logic [14:0]          tgt_rd, q_rd;
  logic [LEN_BITS-1:0]  len_rd;
  logic [DIST_BITS-1:0] d1_rd, d2_rd;
  logic                 seen_rd;

  // Port controls
  logic                 head_we, head_re, link_we, link_re, seen_we, seen_re;
  logic                 d1_we, d2_we, d1_re, d2_re, q_we, q_re;
  logic [NODE_BITS-1:0] head_wa, head_ra, seen_wa, seen_ra, d1_wa, d2_wa, d1_ra, d2_ra;
  logic [NODE_BITS-1:0] q_wa, q_ra;
  logic [HEAD_BITS-1:0] head_wd, onw_wd;
  logic [LINK_BITS-1:0] link_wa, link_ra;
  logic [14:0]          tgt_wd, q_wd;
  logic                 seen_wd;
  logic [DIST_BITS-1:0] dist_wd;

  logic [NCNT_BITS-1:0] n_eff;
  logic [14:0]          walk_src;
  logic [DIST_BITS-1:0] walk_rd;
  logic [DIST_BITS:0]   dist_sum;
  logic [DIST_BITS-1:0] dist_new;
  logic                 visit_ok;

  assign n_eff    = NCNT_BITS'((32'(node_count) < MAX_NODES) ? 32'(node_count) : MAX_NODES);
  assign walk_src = cmd.src_best ? best : start;
  assign walk_rd  = cmd.dest_d2 ? d2_rd : d1_rd;
  assign dist_sum = {1'b0, cur_du} + (DIST_BITS + 1)'(cur_len);
  assign dist_new = dist_sum[DIST_BITS] ? DIST_MAX : dist_sum[DIST_BITS-1:0];
  assign visit_ok = ((NCNT_BITS + 1)'(cur_x) < (NCNT_BITS + 1)'(n_eff)) && !seen_rd &&
                    (32'(qtail) < MAX_NODES);

  assign status.sweep_last  = (sweep_idx == NODE_BITS'(MAX_NODES - 1));
  assign status.queue_empty = (qhead == qtail);
  assign status.link_null   = (cur_l == '0);
  assign status.edge_ok     = ((NCNT_BITS + 1)'(req_a) < (NCNT_BITS + 1)'(n_eff)) &&
                              ((NCNT_BITS + 1)'(req_b) < (NCNT_BITS + 1)'(n_eff)) &&
                              (32'(links) + 2 <= LINK_DEPTH);
  assign status.start_ok    = ((NCNT_BITS + 1)'(start) < (NCNT_BITS + 1)'(n_eff));
  assign status.query_ok    = ((NCNT_BITS + 1)'(req_q) < (NCNT_BITS + 1)'(n_eff));
  assign status.out_full    = out_valid && !out_ready;

  always_comb begin
    head_we = 1'b0; head_re = 1'b0; head_wa = '0; head_ra = '0; head_wd = '0;
    link_we = 1'b0; link_re = 1'b0; link_wa = '0; link_ra = '0;
    tgt_wd  = '0;   onw_wd  = '0;
    seen_we = 1'b0; seen_re = 1'b0; seen_wa = '0; seen_ra = '0; seen_wd = 1'b0;
    d1_we   = 1'b0; d2_we   = 1'b0; d1_re   = 1'b0; d2_re   = 1'b0;
    d1_wa   = '0;   d2_wa   = '0;   d1_ra   = '0;   d2_ra   = '0;   dist_wd = '0;
    q_we    = 1'b0; q_re    = 1'b0; q_wa    = '0;   q_ra    = '0;   q_wd    = '0;
    case (cmd.op)
      OP_SWEEP: begin
        head_we = cmd.clr_head; head_wa = sweep_idx;
        seen_we = cmd.clr_seen; seen_wa = sweep_idx;
        d1_we   = cmd.clr_d1;   d1_wa   = sweep_idx;
        d2_we   = cmd.clr_d2;   d2_wa   = sweep_idx;
      end
      OP_EDGE_RDA: begin
        head_re = 1'b1; head_ra = NODE_BITS'(req_a);
      end
      OP_EDGE_WRA: begin
        link_we = 1'b1; link_wa = links[LINK_BITS-1:0];
        tgt_wd  = req_b; onw_wd = head_rd;
        head_we = 1'b1; head_wa = NODE_BITS'(req_a); head_wd = links + 1'b1;
      end
      OP_EDGE_RDB: begin
        head_re = 1'b1; head_ra = NODE_BITS'(req_b);
      end
      OP_EDGE_WRB: begin
        link_we = 1'b1; link_wa = LINK_BITS'(links + 1'b1);
        tgt_wd  = req_a; onw_wd = head_rd;
        head_we = 1'b1; head_wa = NODE_BITS'(req_b); head_wd = links + 2'd2;
      end
      OP_WALK_INIT: begin
        seen_we = 1'b1; seen_wa = NODE_BITS'(walk_src); seen_wd = 1'b1;
        d1_we   = !cmd.dest_d2; d2_we = cmd.dest_d2;
        d1_wa   = NODE_BITS'(walk_src); d2_wa = NODE_BITS'(walk_src);
        q_we    = 1'b1; q_wa = '0; q_wd = walk_src;
      end
      OP_POP: begin
        q_re = 1'b1; q_ra = qhead[NODE_BITS-1:0];
      end
      OP_NODE_RD: begin
        head_re = 1'b1; head_ra = NODE_BITS'(q_rd);
        d1_re   = !cmd.dest_d2; d2_re = cmd.dest_d2;
        d1_ra   = NODE_BITS'(q_rd); d2_ra = NODE_BITS'(q_rd);
      end
      OP_LINK_RD: begin
        link_re = 1'b1; link_ra = LINK_BITS'(cur_l - 1'b1);
      end
      OP_SEEN_RD: begin
        seen_re = 1'b1; seen_ra = NODE_BITS'(tgt_rd);
      end
      OP_VISIT: begin
        seen_we = visit_ok; seen_wa = NODE_BITS'(cur_x); seen_wd = 1'b1;
        d1_we   = visit_ok && !cmd.dest_d2; d2_we = visit_ok && cmd.dest_d2;
        d1_wa   = NODE_BITS'(cur_x); d2_wa = NODE_BITS'(cur_x); dist_wd = dist_new;
        q_we    = visit_ok; q_wa = qtail[NODE_BITS-1:0]; q_wd = cur_x;
      end
      OP_QUERY_RD: begin
        d1_re = 1'b1; d2_re = 1'b1;
        d1_ra = NODE_BITS'(req_q); d2_ra = NODE_BITS'(req_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      tgt_mem[link_wa] <= tgt_wd;
      onw_mem[link_wa] <= onw_wd;
      len_mem[link_wa] <= req_w;
    end
    if (link_re) begin
      tgt_rd <= tgt_mem[link_ra];
      onw_rd <= onw_mem[link_ra];
      len_rd <= len_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    if (seen_re) seen_rd <= seen_mem[seen_ra];
  end

  always_ff @(posedge clk) begin
    if (d1_we) d1_mem[d1_wa] <= dist_wd;
    if (d1_re) d1_rd <= d1_mem[d1_ra];
  end

  always_ff @(posedge clk) begin
    if (d2_we) d2_mem[d2_wa] <= dist_wd;
    if (d2_re) d2_rd <= d2_mem[d2_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_wa] <= q_wd;
    if (q_re) q_rd <= queue_mem[q_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 16'd1;
      links      <= '0;
      start      <= '0;
      sweep_idx  <= '0;
      qhead      <= '0;
      qtail      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) node_count <= cfg_data;
      if (cmd.op == OP_SWEEP) begin
        sweep_idx <= status.sweep_last ? '0 : sweep_idx + 1'b1;
        if (cmd.clr_head) links <= '0;
      end
      if (cmd.op == OP_EDGE_WRB) begin
        links <= links + 2'd2;
        start <= req_a;
      end
      if (cmd.op == OP_WALK_INIT) begin
        qhead <= '0;
        qtail <= NCNT_BITS'(1);
      end
      if (cmd.op == OP_POP) qhead <= qhead + 1'b1;
      if (cmd.op == OP_VISIT && visit_ok) qtail <= qtail + 1'b1;
      if (cmd.op == OP_QUERY_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_a <= in_data.end_a;
        req_b <= in_data.end_b;
        req_w <= LEN_BITS'(in_data.edge_weight);
        req_q <= in_data.query_node;
      end
      OP_WALK_INIT: begin
        best  <= walk_src;
        bestd <= '0;
      end
      OP_NODE_RD: cur_u <= q_rd;
      OP_NODE: begin
        cur_du <= walk_rd;
        cur_l  <= head_rd;
        if (walk_rd > bestd || (walk_rd == bestd && cur_u < best)) begin
          bestd <= walk_rd;
          best  <= cur_u;
        end
      end
      OP_SEEN_RD: begin
        cur_x   <= tgt_rd;
        cur_len <= len_rd;
        cur_onw <= onw_rd;
      end
      OP_VISIT: cur_l <= cur_onw;
      OP_QUERY_OUT: begin
        out_data.node_index        <= req_q;
        out_data.farthest_distance <= (d1_rd > d2_rd) ? d1_rd : d2_rd;
      end
      default: ;
    endcase
  end

endmodule

[sv/tree_farthest_distance_core.sv]
// Top level of the tree farthest distance block: controller plus datapath.
//
// Load a tree edge by edge, send a compute request, then ask for any node's
// farthest weighted distance (its eccentricity, the larger of its distances to
// the two ends of a diameter). An edge request holds ready low while it
// updates both list heads and stores both links (only for the check when it is
// dropped for an endpoint past node_count or a full link store). A query holds
// ready low while it reads both distance stores (only for the check when the
// node is past node_count, not at all before a compute), and while a previous
// answer still sits untaken in the output register; the answer waits there
// while the next request is taken. After reset, and on the first edge after a
// compute, the head-of-list store is swept one entry a cycle over all
// MAX_NODES (32768) entries first. A compute request runs up to three
// breadth-first walks; each first sweeps the seen marks, the first two also
// the distance stores, then visits each reached node and stored link through
// the single read port of each on-chip memory. Request type 3 and queries
// before a compute or past node_count give no answer. node_count is to be
// written through its own port only while the block is idle, which the block
// itself does not enforce; ready on that port is always high.
module tree_farthest_distance_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tfd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tfd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import tfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Config writes are always accepted.
  assign cfg_ready = 1'b1;

  // Sequence each request and walk step.
  tfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Hold the tree, the walk queue and both distance stores.
  tfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  // A request is latched only on a real handshake.
  a_latch_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LATCH) |-> (in_valid && in_ready))
    else $error("request latched without handshake");

  // Never overwrite an answer that has not been taken.
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_QUERY_OUT) |-> !status.out_full)
    else $error("answer overwrote a pending result");

  // An answer load shows up on the output next cycle.
  a_result_follows_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_QUERY_OUT) |=> out_valid)
    else $error("answer load did not raise out_valid");

  // Idle means every walk has drained its queue.
  a_idle_queue_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> status.queue_empty)
    else $error("ready while walk queue not drained");

endmodule

[test/tree_farthest_distance_core_tb.sv]
// Self-checking testbench for tree_farthest_distance_core: trees, computes, queries.
//
// Stimulus runs in named test tasks, one per feature, called in turn from one
// initial block. All of them send requests through send_request. That task
// also updates the testbench's own model of the tree and of the eccentricity
// answers at the moment the block accepts each request. A separate receiver
// process takes the answers, stalls at random, and checks every field against
// the oldest answer still waiting. Configuration is written only while the
// block is idle.
module tree_farthest_distance_core_tb;
  import tfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINK_SLOTS = 2 * MAX_NODES;
  localparam int SAT_DIST   = 32'h7FFF_FFFF;
  localparam int HOLD_LONG  = 400;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  tree_farthest_distance_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's state: node count, adjacency lists, distance stores.
  int unsigned node_limit;
  int unsigned list_head [MAX_NODES];
  int unsigned link_to [LINK_SLOTS];
  int unsigned link_next [LINK_SLOTS];
  int unsigned link_len [LINK_SLOTS];
  int unsigned dist_a [MAX_NODES];
  int unsigned dist_b [MAX_NODES];
  int unsigned walk_dist [MAX_NODES];
  bit visited [MAX_NODES];
  int unsigned link_count;
  int unsigned root_node;
  bit computed;

  out_item_t answer_q[$];
  int error_count = 0;
  int answers_checked = 0;
  int requests_sent = 0;
  int computes_sent = 0;
  int hold_request = 0;
  bit calm = 1'b0;

  function automatic int unsigned active_nodes();
    return (node_limit < MAX_NODES) ? node_limit : MAX_NODES;
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < MAX_NODES; i++) begin
      list_head[i] = 0;
      dist_a[i] = 0;
      dist_b[i] = 0;
    end
    link_count = 0;
  endfunction

  // Breadth-first walk into walk_dist; return the farthest node, lowest index
  // winning ties. Saturate distances at the 31-bit maximum.
  function automatic int unsigned bfs_farthest(int unsigned src, int unsigned n);
    int unsigned fifo[$];
    int unsigned u, l, x, best, bestd;
    longint unsigned d;
    for (int i = 0; i < MAX_NODES; i++) begin
      visited[i] = 1'b0;
      walk_dist[i] = 0;
    end
    best = src;
    bestd = 0;
    visited[src] = 1'b1;
    fifo = {fifo, src};
    while (fifo.size() > 0) begin
      u = fifo.pop_front();
      if (walk_dist[u] > bestd || (walk_dist[u] == bestd && u < best)) begin
        bestd = walk_dist[u];
        best = u;
      end
      l = list_head[u];
      while (l != 0) begin
        x = link_to[l-1];
        if (x < n && !visited[x]) begin
          d = longint'(walk_dist[u]) + link_len[l-1];
          visited[x] = 1'b1;
          walk_dist[x] = (d > SAT_DIST) ? SAT_DIST : int'(d);
          fifo = {fifo, x};
        end
        l = link_next[l-1];
      end
    end
    return best;
  endfunction

  function automatic void push_link(int unsigned from, int unsigned to, int unsigned len);
    link_to[link_count] = to;
    link_len[link_count] = len;
    link_next[link_count] = list_head[from];
    list_head[from] = link_count + 1;
    link_count++;
  endfunction

  // Update the mirror for one accepted request; queue the answer it causes.
  function automatic void predict_request(in_item_t r);
    int unsigned n, e1, e2, d1, d2;
    out_item_t ans;
    n = active_nodes();
    case (r.req_type)
      REQ_EDGE: begin
        if (computed) begin
          clear_tree();
          computed = 1'b0;
        end
        if (r.end_a < n && r.end_b < n && link_count + 2 <= LINK_SLOTS) begin
          push_link(r.end_a, r.end_b, r.edge_weight);
          push_link(r.end_b, r.end_a, r.edge_weight);
          root_node = r.end_a;
        end
      end
      REQ_COMPUTE: begin
        for (int i = 0; i < MAX_NODES; i++) begin
          dist_a[i] = 0;
          dist_b[i] = 0;
        end
        if (root_node < n) begin
          e1 = bfs_farthest(root_node, n);
          e2 = bfs_farthest(e1, n);
          dist_a = walk_dist;
          void'(bfs_farthest(e2, n));
          dist_b = walk_dist;
        end
        computed = 1'b1;
      end
      REQ_QUERY: begin
        if (computed && r.query_node < n) begin
          d1 = dist_a[r.query_node];
          d2 = dist_b[r.query_node];
          ans.node_index = r.query_node;
          ans.farthest_distance = 31'((d1 > d2) ? d1 : d2);
          answer_q = {answer_q, ans};
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one request after a random gap; return at the edge it is taken.
  // Valid stays high on return so back-to-back requests never drop it.
  task automatic send_request(in_item_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_request(r);
    requests_sent++;
    if (r.req_type == REQ_COMPUTE) computes_sent++;
  endtask

  task automatic send_edge(int a, int b, int w);
    in_item_t r;
    r = '0;
    r.req_type = REQ_EDGE;
    r.end_a = 15'(a);
    r.end_b = 15'(b);
    r.edge_weight = 16'(w);
    r.query_node = 15'($urandom());
    send_request(r);
  endtask

  task automatic send_op(logic [1:0] op, int q);
    in_item_t r;
    r = in_item_t'(63'({$urandom(), $urandom()}));
    r.req_type = op;
    r.query_node = 15'(q);
    send_request(r);
  endtask

  // Drop valid, drain every answer, and wait for the block to report ready.
  task automatic settle();
    in_valid <= 1'b0;
    wait (answer_q.size() == 0);
    do @(negedge clk); while (!in_ready);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= 16'(v);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    node_limit = v;
  endtask

  // Receiver: random stall per answer, or a long hold when one is requested.
  initial begin
    int stall;
    out_item_t got, want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = out_data;
      @(posedge clk);
      if (answer_q.size() == 0) begin
        $error("unexpected answer node_index=%0d farthest_distance=%0d",
               got.node_index, got.farthest_distance);
        error_count++;
      end else begin
        want = answer_q.pop_front();
        answers_checked++;
        if (got.node_index !== want.node_index) begin
          $error("node_index expected %0d actual %0d", want.node_index, got.node_index);
          error_count++;
        end
        if (got.farthest_distance !== want.farthest_distance) begin
          $error("farthest_distance expected %0d actual %0d",
                 want.farthest_distance, got.farthest_distance);
          error_count++;
        end
      end
    end
  end

  // Queries before any compute, unused request type, out-of-range edges.
  task automatic test_before_compute();
    send_op(REQ_QUERY, 0);
    send_op(REQ_UNUSED, 0);
    send_edge(0, 1, 5);
    send_edge(32767, 0, 9);
    send_op(REQ_QUERY, 0);
  endtask

  // One node, no edges: the only node answers zero.
  task automatic test_single_node();
    send_op(REQ_COMPUTE, 0);
    send_op(REQ_QUERY, 0);
    send_op(REQ_QUERY, 1);
    send_op(REQ_QUERY, 32767);
  endtask

  // Small tree with weight extremes and a tie, then a second compute over it.
  task automatic test_directed_tree();
    write_node_count(8);
    send_edge(3, 1, 0);
    send_edge(1, 0, 65535);
    send_edge(1, 2, 65535);
    send_edge(2, 4, 7);
    send_edge(8, 2, 1);
    send_edge(5, 4, 16'h5555);
    send_edge(4, 6, 16'hAAAA);
    send_op(REQ_QUERY, 2);
    send_op(REQ_COMPUTE, 0);
    for (int q = 0; q < 9; q++) send_op(REQ_QUERY, q);
    send_op(REQ_COMPUTE, 0);
    send_op(REQ_QUERY, 7);
    send_op(REQ_QUERY, 0);
  endtask

  // Shrink the count below the start node, with a cycle loaded: all zero.
  task automatic test_start_out_of_range();
    send_edge(0, 1, 3);
    send_edge(1, 2, 4);
    send_edge(2, 0, 5);
    send_edge(7, 2, 6);
    write_node_count(4);
    send_op(REQ_COMPUTE, 0);
    for (int q = 0; q < 5; q++) send_op(REQ_QUERY, q);
  endtask

  // Largest count, clamped to the node limit; endpoints at the top index.
  task automatic test_full_range();
    write_node_count(16'hFFFF);
    send_edge(32767, 0, 1000);
    send_edge(16384, 32767, 2000);
    send_edge(0, 21845, 3000);
    send_op(REQ_COMPUTE, 0);
    send_op(REQ_QUERY, 32767);
    send_op(REQ_QUERY, 21845);
    send_op(REQ_QUERY, 10922);
    write_node_count(32768);
    send_op(REQ_QUERY, 16384);
  endtask

  // Random tree on distinct labels, noise mixed in, then a burst of queries.
  task automatic test_random_tree(int unsigned count, int nodes, int queries, bit squeeze);
    int unsigned label[$];
    bit taken [int unsigned];
    int unsigned v, p;
    write_node_count(count);
    while (label.size() < nodes) begin
      v = $urandom_range(0, count - 1);
      if (!taken.exists(v)) begin
        taken[v] = 1'b1;
        label = {label, v};
      end
    end
    for (int i = 1; i < nodes; i++) begin
      p = label[$urandom_range(0, i - 1)];
      if ($urandom_range(0, 1)) send_edge(label[i], p, $urandom());
      else send_edge(p, label[i], $urandom_range(0, 3) == 0 ? 65535 : $urandom());
      case ($urandom_range(0, 9))
        0: send_op(REQ_UNUSED, $urandom());
        1: send_op(REQ_QUERY, label[$urandom_range(0, i)]);
        2: send_edge($urandom_range(count, 32767), $urandom(), $urandom());
        default: ;
      endcase
    end
    send_op(REQ_COMPUTE, 0);
    if (squeeze) hold_request = HOLD_LONG;
    for (int i = 0; i < queries; i++) begin
      calm = (i % 40) >= 30;
      if ($urandom_range(0, 9) == 0) send_op(REQ_QUERY, $urandom());
      else send_op(REQ_QUERY, label[$urandom_range(0, nodes - 1)]);
    end
    calm = 1'b0;
  endtask

  initial begin
    node_limit = 1;
    computed = 1'b0;
    root_node = 0;
    clear_tree();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_compute();
    test_single_node();
    test_directed_tree();
    test_start_out_of_range();
    test_full_range();
    test_random_tree(48, 30, 180, 1'b1);
    test_random_tree(32768, 40, 180, 1'b0);
    test_random_tree(2, 2, 60, 1'b0);

    settle();
    repeat (100) @(posedge clk);
    $display("Sent %0d requests including %0d computes; checked %0d answers.",
             requests_sent, computes_sent, answers_checked);
    $display("Covered counts 1 to 65535, weight extremes, stalls and a long output hold.");
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("tree_farthest_distance_core_tb passed");
    end else begin
      $display("tree_farthest_distance_core_tb failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tree_farthest_distance_core_tb failed");
    $finish;
  end

endmodule
